FILE: sv/decimal_countdown_alarm_timer_defines.svh
// Assertion helpers shared by the timer RTL.
`ifndef DECIMAL_COUNTDOWN_ALARM_TIMER_DEFINES_SVH
`define DECIMAL_COUNTDOWN_ALARM_TIMER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define DCAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define DCAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/dcat_pkg.sv
`default_nettype none

package dcat_pkg;

  localparam int COUNT_W = 27;
  localparam int CMD_W   = 2;

  localparam logic [3:0]  CODE_BLANK  = 4'd15;
  // floor(v / 10) = (v * RECIP_DIV10) >> DIV10_SHIFT for any 32-bit v
  localparam logic [31:0] RECIP_DIV10 = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_TICK = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  // one emission job per request
  typedef struct packed {
    logic               has_writes;  // display writes of value
    logic               tail;        // extra zero write at the end
    logic               buzzer;
    logic               armed;
    logic [COUNT_W-1:0] value;
  } job_t;

endpackage

`default_nettype wire

FILE: sv/dcat_ctrl.sv
`default_nettype none

module dcat_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [dcat_pkg::COUNT_W-1:0]  load_value,
  input  wire logic [dcat_pkg::CMD_W-1:0]    command,
  input  wire logic                          job_ready,
  output logic                               job_load,
  output dcat_pkg::job_t                     job
);

  `include "decimal_countdown_alarm_timer_defines.svh"

  logic [dcat_pkg::COUNT_W-1:0] count, count_next, count_dec;
  logic armed_flag, armed_flag_next;
  logic ticking, ticking_next;
  logic buzzer, buzzer_next;

  assign s_axis_tready = job_ready;
  assign job_load      = s_axis_tvalid && job_ready;

  assign count_dec = (count != '0) ? (count - dcat_pkg::COUNT_W'(1)) : count;

  always_comb begin
    count_next      = count;
    armed_flag_next = armed_flag;
    ticking_next    = ticking;
    buzzer_next     = buzzer;
    job.has_writes  = 1'b0;
    job.tail        = 1'b0;
    job.value       = count;
    case (command)
      dcat_pkg::CMD_LOAD: begin
        if (!armed_flag) begin
          count_next = load_value;
          if (load_value != '0) begin
            armed_flag_next = 1'b1;
            ticking_next    = 1'b1;
          end
        end
      end
      dcat_pkg::CMD_TICK: begin
        if (ticking) begin
          job.has_writes = 1'b1;
          count_next     = count_dec;
          if (count_dec == '0) begin
            job.tail     = 1'b1;
            buzzer_next  = 1'b1;
            ticking_next = 1'b0;
          end
        end
      end
      dcat_pkg::CMD_STOP: begin
        count_next      = '0;
        armed_flag_next = 1'b0;
        ticking_next    = 1'b0;
        buzzer_next     = 1'b0;
      end
      default: begin
      end
    endcase
    job.buzzer = buzzer_next;
    job.armed  = armed_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      armed_flag <= 1'b0;
      ticking    <= 1'b0;
      buzzer     <= 1'b0;
    end else if (job_load) begin
      count      <= count_next;
      armed_flag <= armed_flag_next;
      ticking    <= ticking_next;
      buzzer     <= buzzer_next;
    end
  end

  `DCAT_ASSERT_NOW(a_tick_needs_arm, ticking, armed_flag, "ticking while disarmed")

endmodule

`default_nettype wire

FILE: sv/dcat_emitter.sv
`default_nettype none

module dcat_emitter #(
  parameter int DIGITS = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_load,
  input  wire dcat_pkg::job_t job,
  output logic                job_ready,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic                write_valid,
  output logic [3:0]          digit_position,
  output logic [3:0]          digit_code,
  output logic                buzzer_on,
  output logic                armed,
  output logic                last
);

  `include "decimal_countdown_alarm_timer_defines.svh"

  localparam int PW = $clog2(DIGITS + 1);
  localparam int CW = dcat_pkg::COUNT_W;
  localparam int QW = CW + 32 - dcat_pkg::DIV10_SHIFT;

  typedef enum logic [1:0] {
    PH_NOWRITE,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  phase_t          phase;
  logic            active;
  logic [CW-1:0]   work;
  logic [PW-1:0]   pos;
  logic            tail;
  logic            job_buzzer, job_armed;

  logic [CW+31:0]  prod;
  logic [QW-1:0]   quot;
  logic [CW-1:0]   rem_full;
  logic [3:0]      rem;
  logic            pos_end;
  logic            gen, fin;
  logic            r_write, r_last;
  logic [3:0]      r_pos, r_code;

  // one decimal digit per result
  assign prod     = (CW+32)'(work) * (CW+32)'(dcat_pkg::RECIP_DIV10);
  assign quot     = prod[CW+31:dcat_pkg::DIV10_SHIFT];
  assign rem_full = work - CW'({quot, 3'b000}) - CW'({quot, 1'b0});
  assign rem      = rem_full[3:0];
  assign pos_end  = (pos == PW'(DIGITS));

  assign gen       = active && (!m_axis_tvalid || m_axis_tready);
  assign job_ready = !active || (gen && fin);

  always_comb begin
    r_write = 1'b0;
    r_pos   = 4'd0;
    r_code  = 4'd0;
    r_last  = 1'b1;
    fin     = 1'b1;
    case (phase)
      PH_NOWRITE: begin
      end
      PH_ZERO: begin
        r_write = 1'b1;
        r_pos   = 4'd1;
        r_last  = !tail;
        fin     = !tail;
      end
      PH_DIGITS: begin
        r_write = 1'b1;
        r_pos   = 4'(pos);
        r_code  = (rem == 4'd0 && quot == '0) ? dcat_pkg::CODE_BLANK : rem;
        r_last  = pos_end && !tail;
        fin     = pos_end && !tail;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      phase         <= PH_NOWRITE;
      tail          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (gen) begin
        m_axis_tvalid  <= 1'b1;
        write_valid    <= r_write;
        digit_position <= r_pos;
        digit_code     <= r_code;
        buzzer_on      <= job_buzzer;
        armed          <= job_armed;
        last           <= r_last;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (job_load) begin
        active     <= 1'b1;
        work       <= job.value;
        pos        <= PW'(1);
        tail       <= job.tail;
        job_buzzer <= job.buzzer;
        job_armed  <= job.armed;
        if (!job.has_writes) begin
          phase <= PH_NOWRITE;
        end else if (job.value == '0) begin
          phase <= PH_ZERO;
        end else begin
          phase <= PH_DIGITS;
        end
      end else if (gen) begin
        if (fin) begin
          active <= 1'b0;
        end else if (phase == PH_DIGITS) begin
          work <= CW'(quot);
          pos  <= pos + PW'(1);
          if (pos_end) begin
            phase <= PH_ZERO;
            tail  <= 1'b0;
          end
        end else begin
          tail <= 1'b0;
        end
      end
    end
  end

  `DCAT_ASSERT_NOW(a_nowrite_last, m_axis_tvalid && !write_valid, last, "no-write result not last")
  `DCAT_ASSERT_NOW(a_code_range, m_axis_tvalid && write_valid, digit_code <= 4'd9 || digit_code == dcat_pkg::CODE_BLANK, "bad digit code")
  `DCAT_ASSERT_NEXT(a_job_continues, gen && !fin && !job_load, active, "job dropped before its last result")

endmodule

`default_nettype wire

FILE: sv/decimal_countdown_alarm_timer.sv
`default_nettype none

// Countdown alarm timer driving a DIGITS-digit decimal display. Requests come in
// on s_axis (tuser = command: load, one-second tick, stop; tdata = load value) and
// are applied to the timer state in the cycle they are accepted. Each request
// yields one or more results on m_axis, the final one marked by tlast. Load, stop
// and idle ticks give a single result and can be accepted one per cycle while
// the output is not stalled. A tick while counting gives DIGITS digit writes, one
// per cycle while the output is not stalled, plus one zero write when the count
// reaches zero. The digits come from the digit emitter, which peels one decimal
// digit per cycle, unless the output stalls, with a multiply-by-reciprocal divide
// by ten. The next request is taken in the cycle the previous one's last result
// is produced into the output register, so no idle slot opens at request boundaries.
module decimal_countdown_alarm_timer #(
  parameter int DIGITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [26:0] load_value, [31:27] zero
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [3:0] digit_position, [7:4] digit_code,
                                           // [8] buzzer_on, [9] armed, [15:10] zero
  output logic             m_axis_tuser,   // [0] write_valid
  output logic             m_axis_tlast    // last
);

  logic           job_ready;
  logic           job_load;
  dcat_pkg::job_t job;
  logic [3:0]     digit_position;
  logic [3:0]     digit_code;
  logic           buzzer_on;
  logic           armed;

  dcat_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .load_value    (s_axis_tdata[dcat_pkg::COUNT_W-1:0]),
    .command       (s_axis_tuser),
    .job_ready     (job_ready),
    .job_load      (job_load),
    .job           (job)
  );

  dcat_emitter #(
    .DIGITS (DIGITS)
  ) u_emitter (
    .clk            (clk),
    .rst            (rst),
    .job_load       (job_load),
    .job            (job),
    .job_ready      (job_ready),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .write_valid    (m_axis_tuser),
    .digit_position (digit_position),
    .digit_code     (digit_code),
    .buzzer_on      (buzzer_on),
    .armed          (armed),
    .last           (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, armed, buzzer_on, digit_code, digit_position};

endmodule

`default_nettype wire
